/* rtl/rsc_pkg.sv */
package rsc_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  // Dividend is a magnitude shifted up by the fraction bits for div
  localparam int unsigned DIV_W       = WORD_W + FRAC_BITS;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_W + 1);

  typedef enum logic [3:0] {
    FN_PUSH  = 4'd0,
    FN_ADD   = 4'd1,
    FN_SUB   = 4'd2,
    FN_MUL   = 4'd3,
    FN_DIV   = 4'd4,
    FN_MOD   = 4'd5,
    FN_POP   = 4'd6,
    FN_PEEK  = 4'd7,
    FN_DUP   = 4'd8,
    FN_SWAP  = 4'd9,
    FN_CLEAR = 4'd10
  } func_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_FULL  = 3'd2,
    ST_ZDIV  = 3'd3,
    ST_SWAP  = 3'd4,
    ST_SAT   = 3'd5
  } status_e;

endpackage

/* rtl/rpn_stack_calculator.sv */
// Reverse Polish calculator on Q16.16 words; the stack lives in a 128-entry synchronous
// memory. A command is taken when start is high and busy is low, and exactly one result
// beat follows on valid_o, for one cycle, in the first cycle that busy is low again; the
// receiver cannot stall it. Every command first reads the top two entries through the
// single read port one after the other, in S_TOP and then S_EXEC, where most finish. Mul
// then writes its product in S_MUL, and a swap with two or more entries writes its
// second word in S_SWAP. Div and mod wait in S_DIV for the shared divider,
// which yields one quotient bit per cycle, unless the divisor (for mod, its integer
// part) is zero. No clearing pass follows reset.
module rpn_stack_calculator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [3:0]                        func_i,
  input  logic signed [rsc_pkg::WORD_W-1:0] operand_i,
  output logic                              valid_o,
  output logic signed [rsc_pkg::WORD_W-1:0] shown_value_o,
  output logic                              shown_o,
  output logic [2:0]                        status_o,
  output logic [7:0]                        depth_o
);
  import rsc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TOP  = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_SWAP = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_e;

  function automatic logic [WORD_W:0] sat32(input logic signed [63:0] v);
    logic [WORD_W:0] r;
    r = {1'b0, v[WORD_W-1:0]};
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (WORD_W'(0) - v) : v;
  endfunction

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_data_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [WORD_W-1:0] mem_wd;

  state_e                   state_q, state_d;
  logic [DEPTH_W-1:0]       depth_q, depth_d;
  status_e                  status_q, status_d;
  logic                     shown_q, shown_d;
  logic                     valid_q, valid_d;
  logic [WORD_W-1:0]        shown_val_q, shown_val_d;
  logic [3:0]               func_q, func_d;
  logic [WORD_W-1:0]        operand_q, operand_d;
  logic signed [WORD_W-1:0] b_q, b_d;
  logic signed [63:0]       prod_q, prod_d;
  logic                     sign_q, sign_d;
  logic                     mod_q, mod_d;

  logic                     has_one, has_two, not_full;
  logic signed [WORD_W-1:0] a_val;
  logic [DEPTH_W-1:0]       nd;
  logic [WORD_W-1:0]        mag_a, mag_b, int_b;
  logic signed [63:0]       a_w, b_w, add_w, mul_sh;
  logic [63:0]              q_w, r_w, dm_w, fin_w;
  logic [WORD_W:0]          add_s, mul_s, fin_s;

  logic                     div_start, div_done;
  logic [DIV_W-1:0]         div_dvd, div_quot;
  logic [WORD_W-1:0]        div_dvs, div_rem;

  rsc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  always_comb begin
    has_one  = depth_q != '0;
    has_two  = depth_q > DEPTH_W'(1);
    not_full = depth_q < DEPTH_W'(STACK_DEPTH);
    // second word arrives from memory in the execute cycle; missing reads as zero
    a_val    = has_two ? rd_data_q : '0;
    nd       = has_two ? (depth_q - DEPTH_W'(2)) : '0;
    mag_a    = mag32(a_val);
    mag_b    = mag32(b_q);
    int_b    = mag_b >> FRAC_BITS;
    a_w      = 64'(a_val);
    b_w      = 64'(b_q);
    add_w    = (func_q == FN_SUB) ? (a_w - b_w) : (a_w + b_w);
    add_s    = sat32(add_w);
    mul_sh   = prod_q >>> FRAC_BITS;
    mul_s    = sat32(mul_sh);
    q_w      = 64'(div_quot);
    r_w      = 64'(div_rem) << FRAC_BITS;
    dm_w     = mod_q ? r_w : q_w;
    fin_w    = sign_q ? (64'd0 - dm_w) : dm_w;
    fin_s    = sat32($signed(fin_w));
    div_dvd  = (func_q == FN_MOD) ? DIV_W'(mag_a >> FRAC_BITS) : (DIV_W'(mag_a) << FRAC_BITS);
    div_dvs  = (func_q == FN_MOD) ? int_b : mag_b;
  end

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    status_d    = status_q;
    shown_d     = shown_q;
    shown_val_d = shown_val_q;
    func_d      = func_q;
    operand_d   = operand_q;
    b_d         = b_q;
    prod_d      = prod_q;
    sign_d      = sign_q;
    mod_d       = mod_q;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    rd_addr     = ADDR_W'(depth_q - DEPTH_W'(1));

    case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d      = func_i;
          operand_d   = operand_i;
          status_d    = ST_OK;
          shown_d     = 1'b0;
          shown_val_d = '0;
          state_d     = S_TOP;
        end
      end
      S_TOP: begin
        b_d     = has_one ? rd_data_q : '0;
        rd_addr = ADDR_W'(depth_q - DEPTH_W'(2));
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (func_q)
          FN_PUSH: begin
            if (not_full) begin
              mem_we  = 1'b1;
              mem_wa  = ADDR_W'(depth_q);
              mem_wd  = operand_q;
              depth_d = depth_q + DEPTH_W'(1);
            end else begin
              status_d = ST_FULL;
            end
          end
          FN_ADD, FN_SUB: begin
            mem_we   = 1'b1;
            mem_wa   = ADDR_W'(nd);
            mem_wd   = add_s[WORD_W-1:0];
            depth_d  = nd + DEPTH_W'(1);
            status_d = add_s[WORD_W] ? ST_SAT : (has_two ? ST_OK : ST_UNDER);
          end
          FN_MUL: begin
            prod_d   = a_val * b_q;
            depth_d  = nd;
            status_d = has_two ? ST_OK : ST_UNDER;
            state_d  = S_MUL;
          end
          FN_DIV, FN_MOD: begin
            if (((func_q == FN_DIV) && (b_q == '0)) ||
                ((func_q == FN_MOD) && (int_b == '0))) begin
              // drop the divisor, leave the dividend in place
              status_d = ST_ZDIV;
              depth_d  = has_one ? (depth_q - DEPTH_W'(1)) : '0;
            end else begin
              div_start = 1'b1;
              depth_d   = nd;
              status_d  = has_two ? ST_OK : ST_UNDER;
              mod_d     = func_q == FN_MOD;
              sign_d    = (func_q == FN_MOD) ? a_val[WORD_W-1] :
                          (a_val[WORD_W-1] ^ b_q[WORD_W-1]);
              state_d   = S_DIV;
            end
          end
          FN_POP: begin
            if (has_one) begin
              shown_d     = 1'b1;
              shown_val_d = b_q;
              depth_d     = depth_q - DEPTH_W'(1);
            end else begin
              status_d = ST_UNDER;
            end
          end
          FN_PEEK: begin
            if (has_one) begin
              shown_d     = 1'b1;
              shown_val_d = b_q;
            end else begin
              status_d = ST_UNDER;
            end
          end
          FN_DUP: begin
            if (!has_one) begin
              status_d = ST_UNDER;
            end else if (!not_full) begin
              status_d = ST_FULL;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = ADDR_W'(depth_q);
              mem_wd  = b_q;
              depth_d = depth_q + DEPTH_W'(1);
            end
          end
          FN_SWAP: begin
            if (has_two) begin
              mem_we  = 1'b1;
              mem_wa  = ADDR_W'(depth_q - DEPTH_W'(1));
              mem_wd  = a_val;
              state_d = S_SWAP;
            end else begin
              status_d = ST_SWAP;
            end
          end
          FN_CLEAR: begin
            depth_d = '0;
          end
          default: begin
          end
        endcase
      end
      S_MUL: begin
        mem_we   = 1'b1;
        mem_wa   = ADDR_W'(depth_q);
        mem_wd   = mul_s[WORD_W-1:0];
        depth_d  = depth_q + DEPTH_W'(1);
        status_d = mul_s[WORD_W] ? ST_SAT : status_q;
        state_d  = S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          mem_we   = 1'b1;
          mem_wa   = ADDR_W'(depth_q);
          mem_wd   = fin_s[WORD_W-1:0];
          depth_d  = depth_q + DEPTH_W'(1);
          status_d = fin_s[WORD_W] ? ST_SAT : status_q;
          state_d  = S_IDLE;
        end
      end
      S_SWAP: begin
        mem_we  = 1'b1;
        mem_wa  = ADDR_W'(depth_q - DEPTH_W'(2));
        mem_wd  = b_q;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    valid_d = (state_q != S_IDLE) && (state_d == S_IDLE);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      depth_q  <= '0;
      status_q <= ST_OK;
      shown_q  <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      depth_q  <= depth_d;
      status_q <= status_d;
      shown_q  <= shown_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shown_val_q <= shown_val_d;
    func_q      <= func_d;
    operand_q   <= operand_d;
    b_q         <= b_d;
    prod_q      <= prod_d;
    sign_q      <= sign_d;
    mod_q       <= mod_d;
  end

  assign busy          = state_q != S_IDLE;
  assign valid_o       = valid_q;
  assign shown_value_o = shown_val_q;
  assign shown_o       = shown_q;
  assign status_o      = status_q;
  assign depth_o       = 8'(depth_q);

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_beat_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !valid_o))
    else $error("accepted command did not occupy the block");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_shown_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && shown_o) |-> (status_o == ST_OK))
    else $error("shown word with a fault status");

endmodule

/* rtl/rsc_div.sv */
module rsc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rsc_pkg::DIV_W-1:0]   dividend_i,
  input  logic [rsc_pkg::WORD_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [rsc_pkg::DIV_W-1:0]   quotient_o,
  output logic [rsc_pkg::WORD_W-1:0]  remainder_o
);
  import rsc_pkg::*;

  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [WORD_W-1:0]    rem_q, rem_d;
  logic [WORD_W-1:0]    dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [WORD_W:0]      rem_sh;
  logic                 ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      cnt_d = DIV_CNT_W'(DIV_W);
      run_d = 1'b1;
    end else if (run_q) begin
      // restoring step: one quotient bit shifts in at the bottom of the dividend
      rem_d = ge ? WORD_W'(rem_sh - {1'b0, dvs_q}) : WORD_W'(rem_sh);
      dvd_d = {dvd_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

/* tb/rpn_step_checker.sv */
module rpn_step_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              busy,
  input  logic [3:0]                        func_i,
  input  logic signed [rsc_pkg::WORD_W-1:0] operand_i,
  input  logic                              valid_i,
  input  logic signed [rsc_pkg::WORD_W-1:0] shown_value_i,
  input  logic                              shown_i,
  input  logic [2:0]                        status_i,
  input  logic [7:0]                        depth_i,
  output int unsigned                       mismatches_o,
  output int unsigned                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rsc_pkg::*;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     shown;
    status_e                  status;
    logic [7:0]               depth;
  } step_result_t;

  localparam longint WORD_HI = (longint'(1) <<< (WORD_W - 1)) - 1;
  localparam longint WORD_LO = -(longint'(1) <<< (WORD_W - 1));

  logic signed [WORD_W-1:0] stack_words [STACK_DEPTH];
  int unsigned              stack_count;
  step_result_t             awaited_beats [$];

  task automatic report(input string what, input logic signed [63:0] got,
                        input logic signed [63:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches_o++;
  endtask

  function automatic logic signed [WORD_W-1:0] pull_word(inout status_e st);
    if (stack_count == 0) begin
      st = ST_UNDER;
      return '0;
    end
    stack_count--;
    return stack_words[stack_count];
  endfunction

  function automatic void place_word(input logic signed [WORD_W-1:0] w, inout status_e st);
    if (stack_count < STACK_DEPTH) begin
      stack_words[stack_count] = w;
      stack_count++;
    end else begin
      st = ST_FULL;
    end
  endfunction

  function automatic logic signed [WORD_W-1:0] saturate(input longint v, inout status_e st);
    if (v > WORD_HI) begin
      st = ST_SAT;
      return WORD_HI[WORD_W-1:0];
    end
    if (v < WORD_LO) begin
      st = ST_SAT;
      return WORD_LO[WORD_W-1:0];
    end
    return v[WORD_W-1:0];
  endfunction

  function automatic longint magnitude(input logic signed [WORD_W-1:0] w);
    longint s;
    s = w;
    return (s < 0) ? -s : s;
  endfunction

  function automatic step_result_t predict_command(input logic [3:0] fn,
                                                   input logic signed [WORD_W-1:0] word);
    step_result_t             r;
    status_e                  st;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    longint                   q;
    longint                   ib;
    st      = ST_OK;
    r.value = '0;
    r.shown = 1'b0;
    case (fn)
      FN_PUSH: place_word(word, st);
      FN_ADD: begin
        b = pull_word(st);
        a = pull_word(st);
        a = saturate(longint'(a) + longint'(b), st);
        place_word(a, st);
      end
      FN_SUB: begin
        b = pull_word(st);
        a = pull_word(st);
        a = saturate(longint'(a) - longint'(b), st);
        place_word(a, st);
      end
      FN_MUL: begin
        b = pull_word(st);
        a = pull_word(st);
        // arithmetic shift floors toward minus infinity
        q = (longint'(a) * longint'(b)) >>> FRAC_BITS;
        a = saturate(q, st);
        place_word(a, st);
      end
      FN_DIV: begin
        b = pull_word(st);
        if (b == 0) begin
          st = ST_ZDIV;
        end else begin
          a = pull_word(st);
          q = (magnitude(a) << FRAC_BITS) / magnitude(b);
          if ((a < 0) != (b < 0)) q = -q;
          a = saturate(q, st);
          place_word(a, st);
        end
      end
      FN_MOD: begin
        b  = pull_word(st);
        ib = magnitude(b) >> FRAC_BITS;
        if (ib == 0) begin
          st = ST_ZDIV;
        end else begin
          a = pull_word(st);
          q = ((magnitude(a) >> FRAC_BITS) % ib) << FRAC_BITS;
          if (a < 0) q = -q;
          a = saturate(q, st);
          place_word(a, st);
        end
      end
      FN_POP: begin
        if (stack_count > 0) begin
          r.value = pull_word(st);
          r.shown = 1'b1;
        end else begin
          st = ST_UNDER;
        end
      end
      FN_PEEK: begin
        if (stack_count > 0) begin
          r.value = stack_words[stack_count-1];
          r.shown = 1'b1;
        end else begin
          st = ST_UNDER;
        end
      end
      FN_DUP: begin
        if (stack_count > 0) begin
          a = stack_words[stack_count-1];
          place_word(a, st);
        end else begin
          st = ST_UNDER;
        end
      end
      FN_SWAP: begin
        if (stack_count > 1) begin
          a = stack_words[stack_count-1];
          stack_words[stack_count-1] = stack_words[stack_count-2];
          stack_words[stack_count-2] = a;
        end else begin
          st = ST_SWAP;
        end
      end
      FN_CLEAR: stack_count = 0;
      default: ;
    endcase
    r.status = st;
    r.depth  = 8'(stack_count);
    return r;
  endfunction

  always @(posedge clk_i) begin
    step_result_t want;
    if (!rst_ni) begin
      stack_count = 0;
      awaited_beats.delete();
      pending_o <= 0;
    end else begin
      // check the returning beat before taking the new command
      if (valid_i) begin
        if (awaited_beats.size() == 0) begin
          report("unexpected result beat, status", 64'(status_i), -1);
        end else begin
          want = awaited_beats.pop_front();
          if (shown_value_i !== want.value) report("shown_value", shown_value_i, want.value);
          if (shown_i !== want.shown) report("shown", 64'(shown_i), 64'(want.shown));
          if (status_i !== want.status) report("status", 64'(status_i), 64'(want.status));
          if (depth_i !== want.depth) report("depth", 64'(depth_i), 64'(want.depth));
        end
      end
      if (start && !busy) awaited_beats.push_back(predict_command(func_i, operand_i));
      pending_o <= awaited_beats.size();
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsc_pkg::*;

  localparam int unsigned   QUIET_LIMIT   = 2000;
  localparam int unsigned   RANDOM_ITEMS  = 640;
  localparam int unsigned   TAIL_CYCLES   = 80;
  localparam logic [3:0]    FN_SPARE_LO   = 4'(FN_CLEAR) + 4'd1;
  localparam logic [3:0]    FN_SPARE_HI   = '1;
  localparam logic [31:0]   Q_MAX         = 32'h7fff_ffff;
  localparam logic [31:0]   Q_MIN         = 32'h8000_0000;
  localparam logic [31:0]   Q_LSB         = 32'h0000_0001;
  localparam logic [31:0]   Q_HALF        = 32'h0000_8000;
  localparam logic [31:0]   Q_MINUS_SEVEN = 32'hfff9_0000;
  localparam logic [31:0]   Q_THREE       = 32'h0003_0000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [3:0]         func_i;
  logic signed [31:0] operand_i;
  logic               valid_o;
  logic signed [31:0] shown_value_o;
  logic               shown_o;
  logic [2:0]         status_o;
  logic [7:0]         depth_o;
  int unsigned        mismatches;
  int unsigned        pending;

  always #1 clk_i = ~clk_i;

  rpn_stack_calculator dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .operand_i,
    .valid_o, .shown_value_o, .shown_o, .status_o, .depth_o
  );

  rpn_step_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .func_i, .operand_i,
    .valid_i(valid_o), .shown_value_i(shown_value_o), .shown_i(shown_o),
    .status_i(status_o), .depth_i(depth_o),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  // hold the command until a rising edge sees busy low, then return on the next falling edge
  task automatic issue(input logic [3:0] fn, input logic [31:0] word);
    start     = 1'b1;
    func_i    = fn;
    operand_i = word;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic pause(input int unsigned cycles);
    if (cycles != 0) begin
      start = 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [31:0] pick_operand();
    int unsigned r;
    logic [31:0] w;
    r = $urandom_range(99);
    if (r < 40) return $urandom;
    if (r < 65) begin
      w = 32'($urandom_range(64)) << FRAC_BITS;
      return $urandom_range(1) ? -w : w;
    end
    if (r < 85) begin
      w = 32'($urandom_range(32'h0004_0000));
      return $urandom_range(1) ? -w : w;
    end
    if (r < 90) return '0;
    if (r < 95) begin
      case ($urandom_range(3))
        0: return Q_MAX;
        1: return Q_MIN;
        2: return Q_LSB;
        default: return '1;
      endcase
    end
    w = 32'($urandom_range(16'hffff));
    return $urandom_range(1) ? -w : w;
  endfunction

  function automatic logic [3:0] pick_func();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return FN_PUSH;
    if (r < 52) return FN_ADD;
    if (r < 58) return FN_SUB;
    if (r < 66) return FN_MUL;
    if (r < 73) return FN_DIV;
    if (r < 80) return FN_MOD;
    if (r < 85) return FN_POP;
    if (r < 88) return FN_PEEK;
    if (r < 92) return FN_DUP;
    if (r < 96) return FN_SWAP;
    if (r < 97) return FN_CLEAR;
    return 4'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
  endfunction

  // drive the stack past full, then work at the top of it
  task automatic fill_stack();
    repeat (STACK_DEPTH + 2) begin
      issue(FN_PUSH, pick_operand());
      pause(pick_gap());
    end
    issue(FN_DUP, pick_operand());
    issue(FN_ADD, pick_operand());
    issue(FN_DUP, pick_operand());
    issue(FN_DUP, pick_operand());
    issue(FN_SWAP, pick_operand());
    issue(FN_POP, pick_operand());
  endtask

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || valid_o) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    func_i    = FN_PUSH;
    operand_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty-stack corners, saturation, zero divisors, flooring and truncation
    issue(FN_POP, '0);
    issue(FN_PEEK, '0);
    issue(FN_DUP, '0);
    issue(FN_ADD, '0);
    issue(FN_SWAP, '0);
    issue(FN_PUSH, Q_MAX);
    issue(FN_ADD, '0);
    issue(FN_DUP, '0);
    issue(FN_ADD, '0);
    issue(FN_PUSH, Q_MIN);
    issue(FN_SUB, '0);
    issue(FN_PUSH, Q_LSB);
    issue(FN_DIV, '0);
    issue(FN_PUSH, '0);
    issue(FN_DIV, '0);
    issue(FN_PUSH, Q_HALF);
    issue(FN_MOD, '0);
    issue(FN_PUSH, Q_MIN);
    issue(FN_MUL, '0);
    issue(FN_PUSH, Q_MINUS_SEVEN);
    issue(FN_PUSH, Q_THREE);
    issue(FN_MOD, '0);
    issue(FN_PUSH, '1);
    issue(FN_PUSH, Q_HALF);
    issue(FN_MUL, '0);
    issue(FN_SWAP, '0);
    issue(FN_PEEK, '0);
    issue(FN_POP, '0);
    issue(FN_SPARE_LO, '1);
    issue(FN_SPARE_HI, '1);
    issue(FN_CLEAR, '0);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) fill_stack();
      if (n == RANDOM_ITEMS / 2) begin
        start = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      issue(pick_func(), pick_operand());
      // a burst without gaps now and then
      if (n % 50 >= 12) pause(pick_gap());
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
rtl/rsc_pkg.sv
rtl/rsc_div.sv
rtl/rpn_stack_calculator.sv
tb/rpn_step_checker.sv
tb/tb.sv
